FILE: hdl/ccr_pkg.sv
package ccr_pkg;

    localparam int MAX_RADIUS   = 80;
    localparam int COORD_BITS   = 12;
    localparam int RESULT_LIMIT = 64;

    localparam int CENTER_BITS  = 16;
    localparam int RADIUS_BITS  = 7;
    localparam int CORNER_BITS  = 2;
    localparam int DIM_BITS     = 13;
    localparam int COLOR_BITS   = 24;

    localparam int OFF_BITS     = 8;
    localparam int D_BITS       = 14;
    localparam int PIX_BITS     = CENTER_BITS + 2;
    localparam int CNT_BITS     = $clog2(RESULT_LIMIT);

    localparam int IN_BITS      = 48;
    localparam int OUT_BITS     = 80;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = COLOR_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DRAW_COLOR    = 2'd2;

    localparam logic [DIM_BITS-1:0]   RESET_WIDTH  = 13'd1024;
    localparam logic [DIM_BITS-1:0]   RESET_HEIGHT = 13'd768;
    localparam logic [COLOR_BITS-1:0] RESET_COLOR  = 24'h0000FF;

    localparam logic [CORNER_BITS-1:0] CORNER_UP_LEFT    = 2'd0;
    localparam logic [CORNER_BITS-1:0] CORNER_UP_RIGHT   = 2'd1;
    localparam logic [CORNER_BITS-1:0] CORNER_DOWN_WIDE  = 2'd2;
    localparam logic [CORNER_BITS-1:0] CORNER_DOWN_STEEP = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } ccr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ccr_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } ccr_status_t;

endpackage

FILE: hdl/ccr_ctrl.sv
module ccr_ctrl
    import ccr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  ccr_status_t status,
    output ccr_cmd_t    cmd
);

    ccr_state_t state_reg;
    ccr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            ST_RUN:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/ccr_datapath.sv
module ccr_datapath
    import ccr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ccr_cmd_t              cmd,
    output ccr_status_t           status,
    input  logic [IN_BITS-1:0]    req_data,
    input  logic [DIM_BITS-1:0]   screen_width,
    input  logic [DIM_BITS-1:0]   screen_height,
    input  logic [COLOR_BITS-1:0] draw_color,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tvalid,
    output logic [OUT_BITS-1:0]   m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam logic [PIX_BITS-2:0] COORD_LIM = (PIX_BITS-1)'(1 << COORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(RESULT_LIMIT - 1);
    localparam logic [RADIUS_BITS-1:0] RADIUS_SAT = RADIUS_BITS'(MAX_RADIUS);

    logic [CENTER_BITS-1:0]  cx_reg;
    logic [CENTER_BITS-1:0]  cy_reg;
    logic [CORNER_BITS-1:0]  corner_reg;
    logic signed [OFF_BITS-1:0] x_reg, x_next;
    logic signed [OFF_BITS-1:0] y_reg, y_next;
    logic signed [D_BITS-1:0]   d_reg, d_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]     m_data_reg;
    logic                    m_last_reg;

    logic [CENTER_BITS-1:0]  req_cx;
    logic [CENTER_BITS-1:0]  req_cy;
    logic [RADIUS_BITS-1:0]  req_r;
    logic [CORNER_BITS-1:0]  req_corner;
    logic [RADIUS_BITS-1:0]  r_sat;

    logic signed [PIX_BITS-1:0] cx_s, cy_s, x_s, y_s;
    logic signed [PIX_BITS-1:0] ax, ay, bx, by;
    logic                    a_ok, b_ok;
    logic [COORD_BITS-1:0]   ax_o, ay_o, bx_o, by_o;
    logic                    last;
    logic signed [OFF_BITS-1:0] x_inc, y_dec;
    logic signed [OFF_BITS-1:0] diff;

    function automatic logic coord_ok(input logic signed [PIX_BITS-1:0] p,
                                      input logic [DIM_BITS-1:0] lim);
        logic ok;
        ok = !p[PIX_BITS-1]
            && (p[PIX_BITS-2:0] < COORD_LIM)
            && (p[PIX_BITS-2:0] < {{(PIX_BITS-1-DIM_BITS){1'b0}}, lim});
        return ok;
    endfunction

    assign req_cx     = req_data[CENTER_BITS-1:0];
    assign req_cy     = req_data[2*CENTER_BITS-1:CENTER_BITS];
    assign req_r      = req_data[2*CENTER_BITS+RADIUS_BITS-1:2*CENTER_BITS];
    assign req_corner = req_data[2*CENTER_BITS+RADIUS_BITS+CORNER_BITS-1:
                                 2*CENTER_BITS+RADIUS_BITS];
    assign r_sat      = (req_r > RADIUS_SAT) ? RADIUS_SAT : req_r;

    // mirrored pixel pair for the current step
    assign cx_s = PIX_BITS'($signed({2'b00, cx_reg}));
    assign cy_s = PIX_BITS'($signed({2'b00, cy_reg}));
    assign x_s  = PIX_BITS'(x_reg);
    assign y_s  = PIX_BITS'(y_reg);

    always_comb
    begin
        case (corner_reg)
            CORNER_UP_LEFT:
            begin
                ax = cx_s - x_s; ay = cy_s - y_s; bx = cx_s - y_s; by = cy_s - x_s;
            end
            CORNER_UP_RIGHT:
            begin
                ax = cx_s + x_s; ay = cy_s - y_s; bx = cx_s + y_s; by = cy_s - x_s;
            end
            CORNER_DOWN_WIDE:
            begin
                ax = cx_s - x_s; ay = cy_s + y_s; bx = cx_s + x_s; by = cy_s + y_s;
            end
            default:
            begin
                ax = cx_s - y_s; ay = cy_s + x_s; bx = cx_s + y_s; by = cy_s + x_s;
            end
        endcase
    end

    assign a_ok = coord_ok(ax, screen_width) && coord_ok(ay, screen_height);
    assign b_ok = coord_ok(bx, screen_width) && coord_ok(by, screen_height);
    assign ax_o = a_ok ? ax[COORD_BITS-1:0] : '0;
    assign ay_o = a_ok ? ay[COORD_BITS-1:0] : '0;
    assign bx_o = b_ok ? bx[COORD_BITS-1:0] : '0;
    assign by_o = b_ok ? by[COORD_BITS-1:0] : '0;

    assign last = (y_reg < x_reg) || (cnt_reg == CNT_MAX);

    assign status.out_free = !m_valid_reg || m_axis_tready;
    assign status.last     = last;

    // recurrence update
    assign x_inc = x_reg + OFF_BITS'(1);
    assign y_dec = y_reg - OFF_BITS'(1);
    assign diff  = x_inc - y_dec;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            x_next   = '0;
            y_next   = OFF_BITS'($signed({1'b0, r_sat}));
            d_next   = D_BITS'(3) - D_BITS'($signed({1'b0, r_sat, 1'b0}));
            cnt_next = '0;
        end
        else if (cmd.step && !last)
        begin
            x_next   = x_inc;
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (d_reg > 0)
            begin
                y_next = y_dec;
                d_next = d_reg + (D_BITS'(diff) <<< 2) + D_BITS'(10);
            end
            else
            begin
                d_next = d_reg + (D_BITS'(x_inc) <<< 2) + D_BITS'(6);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            cx_reg     <= req_cx;
            cy_reg     <= req_cy;
            corner_reg <= req_corner;
        end
        if (cmd.step)
        begin
            m_data_reg <= {{(OUT_BITS - COLOR_BITS - 4*COORD_BITS - 2){1'b0}},
                           draw_color, b_ok, by_o, bx_o, a_ok, ay_o, ax_o};
            m_last_reg <= last;
        end
    end

    always_comb
    begin
        if (cmd.step)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    a_step_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!m_valid_reg || m_axis_tready))
        else $error("step issued while output stalled");

    a_no_load_during_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.step))
        else $error("load and step in the same cycle");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && last) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final step not marked last");

    a_count_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cnt_reg == '0 && x_reg == '0))
        else $error("step state not cleared on load");

endmodule

FILE: hdl/circle_corner_rasterizer_unit.sv
// a request is loaded into the center, corner and x/y/decision registers; each step then registers a result
// an arc yields up to 64 results, one per recurrence step
// one recurrence step per cycle while the output is not stalled, set by the x/y/decision register loop
// the next request is taken in the cycle after the final result is registered
// reset: asynchronous active-low; registers return to 1024, 768, 0x0000ff, no output pending
module circle_corner_rasterizer_unit
    import ccr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // center_x, center_y, radius, corner, zero fill
    input  logic [IN_BITS-1:0]       s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // first_x, first_y, first_valid, second_x, second_y, second_valid, pixel_color, zero fill
    output logic [OUT_BITS-1:0]      m_axis_tdata,
    output logic                     m_axis_tlast
);

    logic [DIM_BITS-1:0]   screen_width_reg;
    logic [DIM_BITS-1:0]   screen_height_reg;
    logic [COLOR_BITS-1:0] draw_color_reg;

    ccr_cmd_t    cmd;
    ccr_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RESET_WIDTH;
            screen_height_reg <= RESET_HEIGHT;
            draw_color_reg    <= RESET_COLOR;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_DRAW_COLOR:    draw_color_reg    <= cfg_data[COLOR_BITS-1:0];
                default:
                begin
                    draw_color_reg <= draw_color_reg;
                end
            endcase
        end
    end

    ccr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    ccr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_data      (s_axis_tdata),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .draw_color    (draw_color_reg),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
